>>> rtl/pus_pkg.sv
// Package for the PNG scanline unfilter: sizes, filter and status codes,
// register indexes, stage types and the Paeth predictor.
// No dependencies.
package pus_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int ROW_ADDR_W      = $clog2(MAX_ROW_BYTES);
  localparam int COL_W           = 14;
  localparam int ROW_W           = 16;
  localparam int PPR_W           = 14;
  localparam int BPP_W           = 4;
  localparam int LEN_W           = PPR_W + BPP_W;
  localparam int SLOT_W          = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 14;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [1:0] STATUS_PIXEL      = 2'd0;
  localparam logic [1:0] STATUS_BAD_FILTER = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_ROW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b1;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        filter;
    logic [7:0]        sample;
    logic [12:0]       column;
    logic              in_store;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic              has_left;
    logic              above_ok;
  } s1_t;

  typedef struct packed {
    logic [7:0]       pixel_value;
    logic [12:0]      column_index;
    logic [ROW_W-1:0] row_index;
    logic             row_last;
    logic [1:0]       status;
  } result_t;

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0]         pa;
    logic [9:0]         pb;
    logic [9:0]         pc;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

>>> rtl/pus_in_if.sv
// Input request channel of the PNG scanline unfilter: one filtered byte.
// Depends on nothing.
interface pus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output data_byte, output chunk_last, input ready);
  modport sink (input valid, input data_byte, input chunk_last, output ready);
endinterface

>>> rtl/pus_out_if.sv
// Result request channel of the PNG scanline unfilter: one reconstructed byte.
// Depends on nothing.
interface pus_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_value;
  logic [12:0] column_index;
  logic [15:0] row_index;
  logic        row_last;
  logic [1:0]  status;

  modport source (output valid, output pixel_value, output column_index, output row_index,
                  output row_last, output status, input ready);
  modport sink (input valid, input pixel_value, input column_index, input row_index,
                input row_last, input status, output ready);
endinterface

>>> rtl/png_scanline_unfilter.sv
// PNG scanline unfilter: reverses the five row filters one byte per cycle,
// filter-type bytes included, while the output is not stalled. A result is
// registered in the reconstruction stage, then in the output register. The
// line store is read at the accepted column and written from that stage.
// Reset (rst_n, synchronous) clears control state and history; the line store
// is not cleared. Depends on pus_pkg, pus_in_if, pus_out_if and pus_ram.
module png_scanline_unfilter
  import pus_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pus_in_if.sink                in_if,
  pus_out_if.source             out_if
);

  logic [PPR_W-1:0]  ppr_r;
  logic [BPP_W-1:0]  bpp_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              expect_r, expect_nxt;
  logic [2:0]        filter_r, filter_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              err_r, err_nxt;
  logic [SLOT_W-1:0] res_r [MAX_PIXEL_BYTES];
  logic              res_clear, res_step;
  logic [7:0]        left_hist_r [MAX_PIXEL_BYTES];
  logic [7:0]        ul_hist_r [MAX_PIXEL_BYTES];

  logic              s1_valid_r, s1_valid_nxt;
  s1_t               s1_r, s1_in;
  logic              s0_emit;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, res1;

  logic              in_accept, out_free, s1_adv;
  logic [BPP_W-1:0]  bpp_eff;
  logic [PPR_W-1:0]  ppr_eff;
  logic [LEN_W-1:0]  row_len;
  logic [SLOT_W-1:0] bpp_m1;

  logic              ram_re, ram_we;
  logic [7:0]        ram_rdata;
  logic [7:0]        above, left, ul, pred, recon;

  // Effective configuration and row length.
  always_comb begin
    bpp_eff = bpp_r;
    if (bpp_r == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end
    ppr_eff = (ppr_r == '0) ? PPR_W'(1) : ppr_r;
    row_len = LEN_W'(ppr_eff) * LEN_W'(bpp_eff);
    bpp_m1  = SLOT_W'(bpp_eff - BPP_W'(1));
  end

  assign out_free  = !out_valid_r || out_if.ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;
  assign in_accept = in_if.valid && in_if.ready;

  // Request acceptance: row control and the line store read.
  always_comb begin
    s0_emit    = 1'b0;
    ram_re     = 1'b0;
    res_clear  = 1'b0;
    res_step   = 1'b0;
    s1_in      = '0;
    col_nxt    = col_r;
    expect_nxt = expect_r;
    filter_nxt = filter_r;
    row_nxt    = row_r;
    err_nxt    = err_r;
    s1_in.row  = row_r;
    if (in_accept && !err_r) begin
      if (expect_r) begin
        if (row_len > LEN_W'(MAX_ROW_BYTES)) begin
          s0_emit      = 1'b1;
          s1_in.status = STATUS_TOO_LONG;
          err_nxt      = 1'b1;
        end else if (in_if.data_byte > 8'(FILT_PAETH)) begin
          s0_emit      = 1'b1;
          s1_in.status = STATUS_BAD_FILTER;
          err_nxt      = 1'b1;
        end else begin
          filter_nxt = in_if.data_byte[2:0];
          col_nxt    = '0;
          expect_nxt = 1'b0;
          res_clear  = 1'b1;
        end
      end else begin
        s0_emit        = 1'b1;
        ram_re         = 1'b1;
        s1_in.status   = STATUS_PIXEL;
        s1_in.filter   = filter_r;
        s1_in.sample   = in_if.data_byte;
        s1_in.column   = col_r[12:0];
        s1_in.in_store = col_r < COL_W'(MAX_ROW_BYTES);
        s1_in.slot     = res_r[bpp_m1];
        s1_in.has_left = col_r >= COL_W'(bpp_eff);
        s1_in.above_ok = (row_r != '0) && (col_r < COL_W'(MAX_ROW_BYTES));
        s1_in.last     = (LEN_W'(col_r) + LEN_W'(1)) >= row_len;
        if (s1_in.last) begin
          expect_nxt = 1'b1;
          col_nxt    = '0;
          res_clear  = 1'b1;
          if (row_r != '1) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
          if (col_r == '1) begin
            res_clear = 1'b1;
          end else begin
            res_step = 1'b1;
          end
        end
      end
    end
    s1_valid_nxt = s0_emit || (s1_valid_r && !out_free);
  end

  pus_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.column[ROW_ADDR_W-1:0]),
    .wdata (recon),
    .re    (ram_re),
    .raddr (col_r[ROW_ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Reconstruction from the line store data and the pixel history.
  always_comb begin
    above = s1_r.above_ok ? ram_rdata : 8'd0;
    left  = s1_r.has_left ? left_hist_r[s1_r.slot] : 8'd0;
    ul    = s1_r.has_left ? ul_hist_r[s1_r.slot] : 8'd0;
    case (s1_r.filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = 8'((9'(left) + 9'(above)) >> 1);
      FILT_PAETH: pred = paeth_pred(left, above, ul);
      default:    pred = 8'd0;
    endcase
    recon  = s1_r.sample + pred;
    ram_we = s1_adv && (s1_r.status == STATUS_PIXEL) && s1_r.in_store;
    res1.row_index = s1_r.row;
    res1.status    = s1_r.status;
    if (s1_r.status == STATUS_PIXEL) begin
      res1.pixel_value  = recon;
      res1.column_index = s1_r.column;
      res1.row_last     = s1_r.last;
    end else begin
      res1.pixel_value  = 8'd0;
      res1.column_index = '0;
      res1.row_last     = 1'b0;
    end
    out_valid_nxt = s1_adv || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r       <= PPR_W'(1);
      bpp_r       <= BPP_W'(1);
      col_r       <= '0;
      expect_r    <= 1'b1;
      filter_r    <= FILT_NONE;
      row_r       <= '0;
      err_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        res_r[i]       <= '0;
        left_hist_r[i] <= 8'd0;
        ul_hist_r[i]   <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PIXELS_PER_ROW:  ppr_r <= cfg_wdata[PPR_W-1:0];
          CFG_BYTES_PER_PIXEL: bpp_r <= cfg_wdata[BPP_W-1:0];
          default:             ppr_r <= ppr_r;
        endcase
      end
      col_r       <= col_nxt;
      expect_r    <= expect_nxt;
      filter_r    <= filter_nxt;
      row_r       <= row_nxt;
      err_r       <= err_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        if (res_clear) begin
          res_r[i] <= '0;
        end else if (res_step) begin
          res_r[i] <= (res_r[i] == SLOT_W'(i)) ? '0 : res_r[i] + SLOT_W'(1);
        end
      end
      if (s1_adv && (s1_r.status == STATUS_PIXEL)) begin
        left_hist_r[s1_r.slot] <= recon;
        ul_hist_r[s1_r.slot]   <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_emit) begin
      s1_r <= s1_in;
    end
    if (s1_adv) begin
      out_r <= res1;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_value  = out_r.pixel_value;
  assign out_if.column_index = out_r.column_index;
  assign out_if.row_index    = out_r.row_index;
  assign out_if.row_last     = out_r.row_last;
  assign out_if.status       = out_r.status;

  // An error, once raised, stays until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error state cleared without reset");

  // The line store is never read and written at the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (s1_r.column[ROW_ADDR_W-1:0] != col_r[ROW_ADDR_W-1:0]))
    else $error("line store read and write collide");

  // A data byte accepted mid-row always reaches the reconstruction stage.
  a_data_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !err_r && !expect_r) |=> s1_valid_r)
    else $error("accepted data byte lost before reconstruction");

  // A stalled reconstruction stage keeps its request.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stalled stage changed");

  // No accepted byte is passed on to reconstruction once an error is raised.
  a_no_emit_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> !s0_emit)
    else $error("result issued after error");

endmodule

>>> rtl/pus_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the read data holds while no read is enabled.
module pus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
